FILE: rtl/mfmfm_pkg.sv
// Shared types, codes and cell-word helpers for the MFM/FM bit-cell decoder.
// No dependencies; imported by every module under rtl.
package mfmfm_pkg;

  // Cells per input byte and per decoded word
  localparam int unsigned CellsPerByte = 8;
  localparam int unsigned WordCells    = 16;

  // MFM sync words and the bytes they stand for
  localparam logic [15:0] MFM_SYNC_A1 = 16'h4489;
  localparam logic [15:0] MFM_SYNC_C2 = 16'h5224;
  localparam logic [7:0]  BYTE_A1     = 8'hA1;
  localparam logic [7:0]  BYTE_C2     = 8'hC2;

  // FM clock patterns
  localparam logic [7:0] FM_CLOCK_MARK  = 8'hC7;
  localparam logic [7:0] FM_CLOCK_INDEX = 8'hD7;

  // Address mark data bytes
  localparam logic [7:0] AM_ID      = 8'hFE;
  localparam logic [7:0] AM_DATA    = 8'hFB;
  localparam logic [7:0] AM_DELDATA = 8'hF8;
  localparam logic [7:0] AM_INDEX   = 8'hFC;

  // Track encoding select
  localparam logic ENC_MFM = 1'b0;
  localparam logic ENC_FM  = 1'b1;

  typedef enum logic [1:0] {
    MARK_NONE  = 2'd0,
    MARK_ID    = 2'd1,
    MARK_DATA  = 2'd2,
    MARK_INDEX = 2'd3
  } mark_e;

  // Scan result handed from the cell scanner to the word decoder
  typedef struct packed {
    logic        emit;
    logic [15:0] word;
  } scan_res_t;

  // Even cells (data), bit 14 -> bit 7
  function automatic logic [7:0] data_cells(input logic [15:0] w);
    logic [7:0] b;
    for (int i = 0; i < 8; i++) begin
      b[i] = w[2*i];
    end
    return b;
  endfunction

  // Odd cells (clock), bit 15 -> bit 7
  function automatic logic [7:0] clock_cells(input logic [15:0] w);
    logic [7:0] b;
    for (int i = 0; i < 8; i++) begin
      b[i] = w[2*i+1];
    end
    return b;
  endfunction

  function automatic logic is_sync(input logic [15:0] w, input logic mode);
    logic [7:0] clk;
    logic [7:0] dat;
    logic       hit;
    clk = clock_cells(w);
    dat = data_cells(w);
    if (mode == ENC_FM) begin
      hit = ((clk == FM_CLOCK_MARK) &&
             (dat == AM_ID || dat == AM_DATA || dat == AM_DELDATA)) ||
            ((clk == FM_CLOCK_INDEX) && (dat == AM_INDEX));
    end else begin
      hit = (w == MFM_SYNC_A1) || (w == MFM_SYNC_C2);
    end
    return hit;
  endfunction

endpackage

FILE: rtl/mfmfm_cell_scan.sv
// Cell window, sync search and phase lock: scans the up to eight window
// positions of one cell byte in parallel. Depends on mfmfm_pkg.
module mfmfm_cell_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  mode_i,
  input  logic [7:0]            cells_i,
  input  logic [3:0]            count_i,
  input  logic                  track_start_i,
  output mfmfm_pkg::scan_res_t  res_o
);
  import mfmfm_pkg::*;

  logic [15:0] win_q, win_d, win_b;
  logic [4:0]  fill_q, fill_d, fill_b;
  logic        lock_q, lock_d, lock_b;
  logic [3:0]  phase_q, phase_d, phase_b;

  logic [3:0]  cnt;
  logic [23:0] ext;
  logic [15:0] win_k [CellsPerByte];
  logic [7:0]  cand;
  logic [2:0]  sel;
  logic        emit;
  logic [5:0]  fill_sum;

  // Track start wipes the state before this byte's cells
  assign win_b   = track_start_i ? '0 : win_q;
  assign fill_b  = track_start_i ? '0 : fill_q;
  assign lock_b  = track_start_i ? 1'b0 : lock_q;
  assign phase_b = track_start_i ? '0 : phase_q;

  assign cnt = (count_i > 4'd8) ? 4'd8 : count_i;

  // Window followed by the cells, first cell next to the window
  always_comb begin
    ext[23:8] = win_b;
    for (int i = 0; i < 8; i++) begin
      ext[7-i] = cells_i[i];
    end
  end

  // One candidate per cell position: sync hit while searching,
  // word boundary while locked
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      win_k[j] = ext[(7-j) +: 16];
      cand[j]  = (4'(j) < cnt) &&
                 (lock_b ? ({1'b0, phase_b} + 5'(j) == 5'd15)
                         : ((6'(fill_b) + 6'(j + 1) >= 6'(WordCells)) &&
                            is_sync(win_k[j], mode_i)));
    end
  end

  // First candidate wins
  always_comb begin
    emit = 1'b0;
    sel  = '0;
    for (int j = 7; j >= 0; j--) begin
      if (cand[j]) begin
        emit = 1'b1;
        sel  = 3'(j);
      end
    end
  end

  // Next state
  always_comb begin
    fill_sum = 6'(fill_b) + 6'(cnt);
    fill_d   = (fill_sum > 6'(WordCells)) ? 5'(WordCells) : fill_sum[4:0];
    lock_d   = lock_b | emit;
    win_d    = (cnt == 4'd0) ? win_b : win_k[3'(cnt - 4'd1)];
    if (emit) begin
      phase_d = 4'(cnt - {1'b0, sel} - 4'd1);
    end else if (lock_b) begin
      phase_d = phase_b + cnt;
    end else begin
      phase_d = phase_b;
    end
  end

  assign res_o.emit = emit;
  assign res_o.word = win_k[sel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      fill_q  <= '0;
      lock_q  <= 1'b0;
      phase_q <= '0;
    end else if (adv_i) begin
      win_q   <= win_d;
      fill_q  <= fill_d;
      lock_q  <= lock_d;
      phase_q <= phase_d;
    end
  end

  // Phase stays at zero while the scanner is searching
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q || (phase_q == 4'd0))
    else $error("phase moved while searching");

  // Fill saturates at one word
  a_fill_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 5'(WordCells))
    else $error("window fill beyond one word");

  // An emitted word leaves the scanner locked afterwards
  a_emit_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && emit |=> lock_q)
    else $error("emitted word without lock");

endmodule

FILE: rtl/mfmfm_word_dec.sv
// Decodes one 16-cell word into data byte, mark kind and sync flag, and
// keeps the MFM after-sync flag. Depends on mfmfm_pkg.
module mfmfm_word_dec (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  mode_i,
  input  logic                  track_start_i,
  input  mfmfm_pkg::scan_res_t  res_i,
  output logic [7:0]            data_o,
  output mfmfm_pkg::mark_e      mark_o,
  output logic                  sync_o
);
  import mfmfm_pkg::*;

  logic       asf_q, asf_d, asf_b;
  logic [7:0] clk_c;
  logic [7:0] dat_c;

  assign asf_b = track_start_i ? 1'b0 : asf_q;
  assign clk_c = clock_cells(res_i.word);
  assign dat_c = data_cells(res_i.word);

  // Mark and data by encoding
  always_comb begin
    data_o = dat_c;
    mark_o = MARK_NONE;
    sync_o = 1'b0;
    asf_d  = asf_b;
    if (mode_i == ENC_FM) begin
      if (clk_c == FM_CLOCK_MARK) begin
        if (dat_c == AM_ID) begin
          mark_o = MARK_ID;
        end else if (dat_c == AM_DATA || dat_c == AM_DELDATA) begin
          mark_o = MARK_DATA;
        end
      end else if (clk_c == FM_CLOCK_INDEX && dat_c == AM_INDEX) begin
        mark_o = MARK_INDEX;
      end
    end else if (res_i.word == MFM_SYNC_A1) begin
      data_o = BYTE_A1;
      sync_o = 1'b1;
      asf_d  = 1'b1;
    end else if (res_i.word == MFM_SYNC_C2) begin
      data_o = BYTE_C2;
      sync_o = 1'b1;
      asf_d  = 1'b1;
    end else begin
      // first byte after a sync run carries the mark
      if (asf_b) begin
        if (dat_c == AM_ID) begin
          mark_o = MARK_ID;
        end else if (dat_c == AM_DATA || dat_c == AM_DELDATA) begin
          mark_o = MARK_DATA;
        end else if (dat_c == AM_INDEX) begin
          mark_o = MARK_INDEX;
        end
      end
      asf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asf_q <= 1'b0;
    end else if (adv_i) begin
      asf_q <= res_i.emit ? asf_d : asf_b;
    end
  end

  // Sync words never carry a mark
  a_sync_nomark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sync_o |-> (mark_o == MARK_NONE))
    else $error("mark on sync word");

  // After-sync flag only rises on an emitted MFM sync word
  a_asf_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !asf_q ##1 asf_q |-> $past(adv_i && res_i.emit && sync_o))
    else $error("after-sync flag set without sync word");

  // FM never reports sync words
  a_fm_nosync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_i == ENC_FM) |-> !sync_o)
    else $error("sync word flagged in FM");

endmodule

FILE: rtl/mfm_fm_cell_decoder.sv
// Top level of the MFM/FM floppy bit-cell decoder: input register, cell
// scanner, word decoder, result register and APB mode register.
// Depends on mfmfm_pkg, mfmfm_cell_scan and mfmfm_word_dec.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   in       | in_valid_i/in_ready_o  | cell_byte_i, cell_count_i, track_start_i
//   out      | out_valid_o/out_ready_i| out_byte_o, mark_kind_o, sync_word_o
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata (encoding_mode)
//
// One cell byte per cycle while the output is not stalled; a result passes the
// input register, then the result register, before it is on the outputs.
// The eight window positions of a byte are compared in parallel in one pass.
// Reset clears mode (MFM), window, lock, phase and after-sync flag.
// A stalled result holds the result register; the input register takes a
// byte when it is empty or when the item it holds can move on.
module mfm_fm_cell_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  cell_byte_i,
  input  logic [3:0]  cell_count_i,
  input  logic        track_start_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  mark_kind_o,
  output logic        sync_word_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mfmfm_pkg::*;

  localparam logic REG_ENCODING_MODE = 1'b0;

  logic       mode_q;
  logic       in_valid_q;
  logic [7:0] cells_q;
  logic [3:0] count_q;
  logic       tstart_q;
  logic       out_valid_q;
  logic [7:0] data_q;
  mark_e      mark_q;
  logic       sync_q;
  logic       adv;

  scan_res_t  scan_res;
  logic [7:0] dec_data;
  mark_e      dec_mark;
  logic       dec_sync;

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENCODING_MODE) ? {31'b0, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ENC_MFM;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_ENCODING_MODE)) begin
      mode_q <= pwdata[0];
    end
  end

  // Input register advances when the result slot is free or draining
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cells_q  <= cell_byte_i;
      count_q  <= cell_count_i;
      tstart_q <= track_start_i;
    end
  end

  mfmfm_cell_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .mode_i        (mode_q),
    .cells_i       (cells_q),
    .count_i       (count_q),
    .track_start_i (tstart_q),
    .res_o         (scan_res)
  );

  mfmfm_word_dec u_dec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .mode_i        (mode_q),
    .track_start_i (tstart_q),
    .res_i         (scan_res),
    .data_o        (dec_data),
    .mark_o        (dec_mark),
    .sync_o        (dec_sync)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && scan_res.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && scan_res.emit) begin
      data_q <= dec_data;
      mark_q <= dec_mark;
      sync_q <= dec_sync;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = data_q;
  assign mark_kind_o = mark_q;
  assign sync_word_o = sync_q;

  // Back-pressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && !out_ready_i))
    else $error("input stalled without output stall");

  // A held request is not dropped while the output stalls
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |=> in_valid_q)
    else $error("request lost during stall");

  // MFM sync results carry A1 or C2
  a_sync_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sync_word_o |-> (out_byte_o == BYTE_A1 || out_byte_o == BYTE_C2))
    else $error("sync result with wrong byte");

endmodule
